>>> rtl/bm25_pkg.sv
package bm25_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int SCORE_FRAC_DEF = 16;

    localparam int LOG_IN_W  = 34;
    localparam int LOG_OUT_W = 34;
    localparam int TAB_W     = 29;
    localparam int DIFF_W    = 22;
    localparam int IDF_W     = 34;
    localparam int NUM_W     = 53;
    localparam int CQ_W      = 61;
    localparam int G_W       = 31;
    localparam int TF_W      = 30;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    localparam logic [31:0] AVG_RST   = 32'd256;
    localparam logic [15:0] K_RST     = 16'd4915;
    localparam logic [12:0] B_RST     = 13'd3072;
    localparam logic [12:0] B_ONE     = 13'd4096;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_FREQ = 2'd2;

    typedef enum logic [1:0] {
        CFG_TOTAL_DOCS = 2'd0,
        CFG_AVG_LEN    = 2'd1,
        CFG_K          = 2'd2,
        CFG_B          = 2'd3
    } t_cfg_idx;

    typedef logic [256:0][TAB_W-1:0] t_log_tab;

    // log2(1 + i/256) in Q28 by repeated squaring
    function automatic t_log_tab f_build_log_tab();
        t_log_tab    tab;
        logic [63:0] m;
        logic [27:0] acc;
        for (int i = 0; i < 256; i++) begin
            m   = 64'(256 + i) << 22;
            acc = '0;
            for (int n = 0; n < 28; n++) begin
                m   = (m * m) >> 30;
                acc = {acc[26:0], 1'b0};
                if (m >= 64'h8000_0000) begin
                    acc[0] = 1'b1;
                    m      = m >> 1;
                end
            end
            tab[i] = {1'b0, acc};
        end
        tab[256] = 29'h1000_0000;
        return tab;
    endfunction

    localparam t_log_tab LOG_TAB = f_build_log_tab();

endpackage

>>> rtl/bm25_log2.sv
module bm25_log2 (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [bm25_pkg::LOG_IN_W-1:0]    i_x,
    output logic [bm25_pkg::LOG_OUT_W-1:0]   o_log
);

    logic [5:0]                        n_p;
    logic [bm25_pkg::LOG_IN_W+31:0]    w_sh;
    logic [5:0]                        r_p1;
    logic [31:0]                       r_frac1;

    logic [7:0]                        w_idx;
    logic [bm25_pkg::TAB_W-1:0]        w_lo;
    logic [bm25_pkg::TAB_W-1:0]        w_hi;
    logic [5:0]                        r_p2;
    logic [27:0]                       r_lo;
    logic [bm25_pkg::DIFF_W-1:0]       r_diff;
    logic [23:0]                       r_w;

    logic [bm25_pkg::DIFF_W+23:0]      w_prod;
    logic [bm25_pkg::LOG_OUT_W-1:0]    r_log;

    // leading one search and normalization
    always_comb begin
        n_p = '0;
        for (int k = 0; k < bm25_pkg::LOG_IN_W; k++) begin
            if (i_x[k]) begin
                n_p = 6'(k);
            end
        end
    end

    assign w_sh = {i_x, 32'b0} >> n_p;

    assign w_idx = r_frac1[31:24];
    assign w_lo  = bm25_pkg::LOG_TAB[w_idx];
    assign w_hi  = bm25_pkg::LOG_TAB[9'({1'b0, w_idx}) + 9'd1];

    assign w_prod = (bm25_pkg::DIFF_W+24)'(r_diff) * (bm25_pkg::DIFF_W+24)'(r_w);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1    <= n_p;
            r_frac1 <= w_sh[31:0];
            r_p2    <= r_p1;
            r_lo    <= w_lo[27:0];
            r_diff  <= bm25_pkg::DIFF_W'(w_hi - w_lo);
            r_w     <= r_frac1[23:0];
            r_log   <= {r_p2, 28'b0} + bm25_pkg::LOG_OUT_W'(r_lo)
                     + bm25_pkg::LOG_OUT_W'(w_prod[bm25_pkg::DIFF_W+23:24]);
        end
    end

    assign o_log = r_log;

endmodule

>>> rtl/bm25_div.sv
module bm25_div #(
    parameter int NUM_W  = 61,
    parameter int DEN_W  = 32,
    parameter int QUO_W  = 61,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [QUO_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    localparam int HI_W = NUM_W - QUO_W;

    logic [DEN_W-1:0]  w_rem0;
    logic              r_vld  [QUO_W];
    logic [DEN_W-1:0]  r_rem  [QUO_W];
    logic [QUO_W-1:0]  r_low  [QUO_W];
    logic [DEN_W-1:0]  r_den  [QUO_W];
    logic [SIDE_W-1:0] r_side [QUO_W];

    generate
        if (HI_W > 0) begin : g_hi
            assign w_rem0 = DEN_W'(i_num[NUM_W-1:QUO_W]);
        end else begin : g_nohi
            assign w_rem0 = '0;
        end
    endgenerate

    // one quotient bit per stage, restoring
    generate
        for (genvar g = 0; g < QUO_W; g++) begin : g_stage
            logic              w_vld_in;
            logic [DEN_W-1:0]  w_rem_in;
            logic [QUO_W-1:0]  w_low_in;
            logic [DEN_W-1:0]  w_den_in;
            logic [SIDE_W-1:0] w_side_in;
            logic [DEN_W:0]    w_t;
            logic              w_ge;
            logic [DEN_W-1:0]  n_rem;
            logic [QUO_W-1:0]  n_low;

            if (g == 0) begin : g_first
                assign w_vld_in  = i_vld;
                assign w_rem_in  = w_rem0;
                assign w_low_in  = i_num[QUO_W-1:0];
                assign w_den_in  = i_den;
                assign w_side_in = i_side;
            end else begin : g_next
                assign w_vld_in  = r_vld[g-1];
                assign w_rem_in  = r_rem[g-1];
                assign w_low_in  = r_low[g-1];
                assign w_den_in  = r_den[g-1];
                assign w_side_in = r_side[g-1];
            end

            assign w_t   = {w_rem_in, w_low_in[QUO_W-1]};
            assign w_ge  = (w_t >= {1'b0, w_den_in});
            assign n_rem = w_ge ? DEN_W'(w_t - {1'b0, w_den_in}) : w_t[DEN_W-1:0];
            assign n_low = {w_low_in[QUO_W-2:0], w_ge};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (i_en) begin
                    r_vld[g] <= w_vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g]  <= n_rem;
                    r_low[g]  <= n_low;
                    r_den[g]  <= w_den_in;
                    r_side[g] <= w_side_in;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[QUO_W-1];
    assign o_quo  = r_low[QUO_W-1];
    assign o_side = r_side[QUO_W-1];

endmodule

>>> rtl/bm25_term_score.sv
// channel   dir  handshake                              payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready       doc_freq, term_freq, doc_length
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready       score, status
// cfg       in   i_cfg_we (no wait)                      i_cfg_idx, i_cfg_data
//
// one posting per cycle unless output stalls; most stages lie in the two dividers
// (61 stages for the length term, 31 stages for the saturation quotient)
// synchronous active-low reset clears valid bits and loads register defaults
// a stall at the output freezes every stage at once; nothing is dropped or repeated
module bm25_term_score #(
    parameter int COUNT_BITS      = bm25_pkg::COUNT_BITS_DEF,
    parameter int SCORE_FRAC_BITS = bm25_pkg::SCORE_FRAC_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [95:0] i_s_axis_tdata,   // doc_freq, term_freq, doc_length
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // score, status, zero pad
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int CW    = COUNT_BITS;
    localparam int X_W   = CW + 16;
    localparam int SH    = 52 - SCORE_FRAC_BITS;
    localparam int MAG_W = 65 - SH;
    localparam int S1_W  = 2 + X_W + 1 + bm25_pkg::IDF_W;
    localparam int S2_W  = 2 + 1 + bm25_pkg::IDF_W;

    logic [31:0] r_total_docs;
    logic [31:0] r_avg_len;
    logic [15:0] r_k;
    logic [12:0] r_b;

    logic        w_en;
    logic [31:0] w_avg;
    logic [12:0] w_bq;
    logic [12:0] w_omb;

    // stage 1
    logic [CW-1:0] w_df;
    logic [CW-1:0] w_f;
    logic [CW-1:0] w_dl;
    logic [1:0]    n1_st;
    logic          r1_vld;
    logic [1:0]    r1_st;
    logic [X_W-1:0] r1_x;
    logic [bm25_pkg::LOG_IN_W-1:0] r1_a;
    logic [bm25_pkg::LOG_IN_W-1:0] r1_b;
    logic [44:0]   r1_p1;
    logic [44:0]   r1_p2;

    // stage 2
    logic          r2_vld;
    logic [1:0]    r2_st;
    logic [X_W-1:0] r2_x;
    logic [bm25_pkg::NUM_W-1:0] r2_num;

    // stage 3
    logic          r3_vld;
    logic [1:0]    r3_st;
    logic [X_W-1:0] r3_x;
    logic [42:0]   r3_pl;
    logic [41:0]   r3_ph;

    // stage 4
    logic [68:0]   w_kn;
    logic          r4_vld;
    logic [1:0]    r4_st;
    logic [X_W-1:0] r4_x;
    logic [bm25_pkg::CQ_W-1:0] r4_n1;
    logic [bm25_pkg::LOG_OUT_W-1:0] w_la;
    logic [bm25_pkg::LOG_OUT_W-1:0] w_lb;

    // stage 5
    logic          r5_vld;
    logic [1:0]    r5_st;
    logic [X_W-1:0] r5_x;
    logic [bm25_pkg::CQ_W-1:0] r5_n1;
    logic          r5_neg;
    logic [bm25_pkg::LOG_OUT_W-1:0] r5_dmag;

    // stage 6
    logic [63:0]   w_idf_prod;
    logic          r6_vld;
    logic [1:0]    r6_st;
    logic [X_W-1:0] r6_x;
    logic [bm25_pkg::CQ_W-1:0] r6_n1;
    logic          r6_neg;
    logic [bm25_pkg::IDF_W-1:0] r6_idf;

    // first divider
    logic          d1_vld;
    logic [bm25_pkg::CQ_W-1:0] d1_c;
    logic [S1_W-1:0] d1_side_in;
    logic [S1_W-1:0] d1_side;
    logic [1:0]    d1_st;
    logic [X_W-1:0] d1_x;
    logic          d1_neg;
    logic [bm25_pkg::IDF_W-1:0] d1_idf;

    // stage 7, 8
    logic          r7_vld;
    logic [1:0]    r7_st;
    logic          r7_neg;
    logic [bm25_pkg::IDF_W-1:0] r7_idf;
    logic [X_W-1:0] r7_x;
    logic [61:0]   r7_dsum;
    logic [5:0]    w_msb;
    logic [4:0]    w_s;
    logic          r8_vld;
    logic [1:0]    r8_st;
    logic          r8_neg;
    logic [bm25_pkg::IDF_W-1:0] r8_idf;
    logic [31:0]   r8_xs;
    logic [31:0]   r8_ds;

    // second divider
    logic          d2_vld;
    logic [bm25_pkg::G_W-1:0] d2_g;
    logic [S2_W-1:0] d2_side;
    logic [1:0]    d2_st;
    logic          d2_neg;
    logic [bm25_pkg::IDF_W-1:0] d2_idf;

    // stages 9 to 11 and output
    logic [16:0]   w_k1;
    logic [47:0]   w_tf_prod;
    logic          r9_vld;
    logic [1:0]    r9_st;
    logic          r9_neg;
    logic [bm25_pkg::IDF_W-1:0] r9_idf;
    logic [bm25_pkg::TF_W-1:0]  r9_tf;
    logic          r10_vld;
    logic [1:0]    r10_st;
    logic          r10_neg;
    logic [46:0]   r10_pl;
    logic [46:0]   r10_ph;
    logic [64:0]   w_prod;
    logic          r11_vld;
    logic [1:0]    r11_st;
    logic          r11_neg;
    logic [MAG_W-1:0] r11_mag;
    logic [63:0]   w_mag64;
    logic [31:0]   n_score;
    logic          r_out_vld;
    logic [31:0]   r_score;
    logic [1:0]    r_status;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_docs <= '0;
            r_avg_len    <= bm25_pkg::AVG_RST;
            r_k          <= bm25_pkg::K_RST;
            r_b          <= bm25_pkg::B_RST;
        end else if (i_cfg_we) begin
            unique case (bm25_pkg::t_cfg_idx'(i_cfg_idx))
                bm25_pkg::CFG_TOTAL_DOCS: r_total_docs <= i_cfg_data;
                bm25_pkg::CFG_AVG_LEN:    r_avg_len    <= i_cfg_data;
                bm25_pkg::CFG_K:          r_k          <= i_cfg_data[15:0];
                bm25_pkg::CFG_B:          r_b          <= i_cfg_data[12:0];
            endcase
        end
    end

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    assign w_avg = (r_avg_len == '0) ? 32'd1 : r_avg_len;
    assign w_bq  = (r_b > bm25_pkg::B_ONE) ? bm25_pkg::B_ONE : r_b;
    assign w_omb = bm25_pkg::B_ONE - w_bq;

    assign w_df = i_s_axis_tdata[CW-1:0];
    assign w_f  = i_s_axis_tdata[32+CW-1:32];
    assign w_dl = i_s_axis_tdata[64+CW-1:64];

    always_comb begin
        if (w_df == '0 || w_f == '0 || w_dl == '0) begin
            n1_st = bm25_pkg::ST_ZERO;
        end else if (32'(w_df) > r_total_docs) begin
            n1_st = bm25_pkg::ST_FREQ;
        end else begin
            n1_st = bm25_pkg::ST_OK;
        end
    end

    bm25_log2 u_log_a (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r1_a),
        .o_log (w_la)
    );

    bm25_log2 u_log_b (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r1_b),
        .o_log (w_lb)
    );

    assign w_kn       = 69'(r3_pl) + {r3_ph, 27'b0};
    assign w_idf_prod = 64'(r5_dmag) * 64'(bm25_pkg::LN2_Q30);

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r8_vld    <= 1'b0;
            r9_vld    <= 1'b0;
            r10_vld   <= 1'b0;
            r11_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld    <= i_s_axis_tvalid;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= r5_vld;
            r7_vld    <= d1_vld;
            r8_vld    <= r7_vld;
            r9_vld    <= d2_vld;
            r10_vld   <= r9_vld;
            r11_vld   <= r10_vld;
            r_out_vld <= r11_vld;
        end
    end

    // front stages: counts, logs, idf, length term numerator
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_st  <= n1_st;
            r1_x   <= {w_f, 16'b0};
            r1_a   <= bm25_pkg::LOG_IN_W'({r_total_docs - 32'(w_df), 1'b1});
            r1_b   <= bm25_pkg::LOG_IN_W'({32'(w_df), 1'b1});
            r1_p1  <= 45'(w_omb) * 45'(w_avg);
            r1_p2  <= 45'(w_bq) * 45'(w_dl);

            r2_st  <= r1_st;
            r2_x   <= r1_x;
            r2_num <= bm25_pkg::NUM_W'(r1_p1) + bm25_pkg::NUM_W'({r1_p2, 8'b0});

            r3_st  <= r2_st;
            r3_x   <= r2_x;
            r3_pl  <= 43'(r_k) * 43'(r2_num[26:0]);
            r3_ph  <= 42'(r_k) * 42'(r2_num[52:27]);

            r4_st  <= r3_st;
            r4_x   <= r3_x;
            r4_n1  <= w_kn[68:8];

            r5_st   <= r4_st;
            r5_x    <= r4_x;
            r5_n1   <= r4_n1;
            r5_neg  <= (w_la < w_lb);
            r5_dmag <= (w_la < w_lb) ? (w_lb - w_la) : (w_la - w_lb);

            r6_st  <= r5_st;
            r6_x   <= r5_x;
            r6_n1  <= r5_n1;
            r6_neg <= r5_neg;
            r6_idf <= w_idf_prod[63:30] + bm25_pkg::IDF_W'(w_idf_prod[29]);
        end
    end

    assign d1_side_in = {r6_st, r6_x, r6_neg, r6_idf};

    bm25_div #(
        .NUM_W  (bm25_pkg::CQ_W),
        .DEN_W  (32),
        .QUO_W  (bm25_pkg::CQ_W),
        .SIDE_W (S1_W)
    ) u_div_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r6_vld),
        .i_num   (r6_n1),
        .i_den   (w_avg),
        .i_side  (d1_side_in),
        .o_vld   (d1_vld),
        .o_quo   (d1_c),
        .o_side  (d1_side)
    );

    assign {d1_st, d1_x, d1_neg, d1_idf} = d1_side;

    always_comb begin
        w_msb = '0;
        for (int k = 0; k < 62; k++) begin
            if (r7_dsum[k]) begin
                w_msb = 6'(k);
            end
        end
    end

    assign w_s = (w_msb > 6'd31) ? 5'(w_msb - 6'd31) : 5'd0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_st   <= d1_st;
            r7_neg  <= d1_neg;
            r7_idf  <= d1_idf;
            r7_x    <= d1_x;
            r7_dsum <= 62'(d1_c) + 62'(d1_x);

            r8_st  <= r7_st;
            r8_neg <= r7_neg;
            r8_idf <= r7_idf;
            r8_xs  <= 32'(r7_x >> w_s);
            r8_ds  <= 32'(r7_dsum >> w_s);
        end
    end

    bm25_div #(
        .NUM_W  (62),
        .DEN_W  (32),
        .QUO_W  (bm25_pkg::G_W),
        .SIDE_W (S2_W)
    ) u_div_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r8_vld),
        .i_num   ({r8_xs, 30'b0}),
        .i_den   (r8_ds),
        .i_side  ({r8_st, r8_neg, r8_idf}),
        .o_vld   (d2_vld),
        .o_quo   (d2_g),
        .o_side  (d2_side)
    );

    assign {d2_st, d2_neg, d2_idf} = d2_side;

    assign w_k1      = 17'(r_k) + 17'd4096;
    assign w_tf_prod = 48'(w_k1) * 48'(d2_g);
    assign w_prod    = 65'(r10_pl) + 65'({r10_ph, 17'b0}) + (65'd1 << (SH - 1));
    assign w_mag64   = 64'(r11_mag);

    always_comb begin
        if (r11_st != bm25_pkg::ST_OK) begin
            n_score = '0;
        end else if (r11_neg) begin
            n_score = (w_mag64 >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - w_mag64);
        end else begin
            n_score = (w_mag64 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : w_mag64[31:0];
        end
    end

    // back stages: tf, product, rounding, saturation
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_st  <= d2_st;
            r9_neg <= d2_neg;
            r9_idf <= d2_idf;
            r9_tf  <= w_tf_prod[bm25_pkg::TF_W+17:18];

            r10_st  <= r9_st;
            r10_neg <= r9_neg;
            r10_pl  <= 47'(r9_idf[16:0]) * 47'(r9_tf);
            r10_ph  <= 47'(r9_idf[33:17]) * 47'(r9_tf);

            r11_st  <= r10_st;
            r11_neg <= r10_neg;
            r11_mag <= w_prod[64:SH];

            r_score  <= n_score;
            r_status <= r11_st;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'b0, r_status, r_score};

`ifndef NO_ASSERTIONS
    a_flag_zero_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[33:32] != bm25_pkg::ST_OK
        |-> o_m_axis_tdata[31:0] == '0)
        else $error("flagged result carries nonzero score");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[33:32] != 2'd3)
        else $error("undefined status code");

    a_neg_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[31] |-> o_m_axis_tdata[33:32] == bm25_pkg::ST_OK)
        else $error("negative score with error status");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !r11_vld && !d2_vld)
        else $error("pipeline not empty after reset");
`endif

endmodule

>>> sim/bm25_term_score_checker.sv
`timescale 1ns / 100ps

module bm25_term_score_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [95:0] i_s_axis_tdata,   // doc_freq, term_freq, doc_length
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [39:0] i_m_axis_tdata,   // score, status, zero pad
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] score;
        logic [1:0]  status;
    } t_score;

    bit [31:0] log2_frac [257];
    bit [31:0] n_docs;
    bit [31:0] avg_len;
    bit [15:0] k_q12;
    bit [12:0] b_q12;
    t_score    score_q [$];

    initial begin
        bit [63:0] m;
        bit [31:0] acc;
        for (int i = 0; i < 256; i++) begin
            m   = 64'(256 + i) << 22;
            acc = 0;
            for (int n = 0; n < 28; n++) begin
                m   = (m * m) >> 30;
                acc = acc << 1;
                if (m >= 64'h8000_0000) begin
                    acc = acc | 1;
                    m   = m >> 1;
                end
            end
            log2_frac[i] = acc;
        end
        log2_frac[256] = 32'h1000_0000;
    end

    function automatic int top_bit(bit [63:0] v);
        int p;
        p = 0;
        for (int j = 1; j < 64; j++)
            if (v[j]) p = j;
        return p;
    endfunction

    function automatic bit [63:0] log2_q28(bit [63:0] v);
        int        p;
        bit [63:0] t;
        bit [31:0] fr;
        bit [63:0] lo, hi, w;
        p  = top_bit(v);
        t  = v << (63 - p);
        fr = t[62:31];
        lo = log2_frac[fr[31:24]];
        hi = log2_frac[fr[31:24] + 1];
        w  = fr[23:0];
        return (64'(p) << 28) + lo + (((hi - lo) * w) >> 24);
    endfunction

    function automatic t_score bm25(bit [31:0] df, bit [31:0] tf_cnt, bit [31:0] dl);
        t_score    res;
        bit [63:0] la, lb, dmag, idf, avg, bq, kq, num, den, q, r, c, x, dsum, g, tfq, prod, mag;
        bit        neg;
        int        s;
        res.score  = 0;
        res.status = bm25_pkg::ST_OK;
        if (df == 0 || tf_cnt == 0 || dl == 0) begin
            res.status = bm25_pkg::ST_ZERO;
            return res;
        end
        if (df > n_docs) begin
            res.status = bm25_pkg::ST_FREQ;
            return res;
        end
        la   = log2_q28(2 * (64'(n_docs) - df) + 1);
        lb   = log2_q28(2 * 64'(df) + 1);
        neg  = la < lb;
        dmag = neg ? lb - la : la - lb;
        idf  = (dmag * 64'(bm25_pkg::LN2_Q30) + (64'd1 << 29)) >> 30;

        avg  = (avg_len == 0) ? 1 : avg_len;
        bq   = (b_q12 > 4096) ? 4096 : b_q12;
        kq   = k_q12;
        num  = (4096 - bq) * avg + bq * 256 * dl;
        den  = 256 * avg;
        q    = num / den;
        r    = num % den;
        c    = kq * q + (kq * r) / den;

        x    = 64'(tf_cnt) << 16;
        dsum = x + c;
        s    = top_bit(dsum) - 31;
        if (s > 0) begin
            x    = x >> s;
            dsum = dsum >> s;
        end
        g    = (x << 30) / dsum;
        tfq  = (((kq + 4096) * g) >> 14) >> 4;

        prod = idf * tfq;
        mag  = (prod + (64'd1 << (51 - bm25_pkg::SCORE_FRAC_DEF)))
             >> (52 - bm25_pkg::SCORE_FRAC_DEF);
        if (neg)
            res.score = (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(0 - mag);
        else
            res.score = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(mag);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_score got, want;
        if (!i_rst_n) begin
            n_docs  = 0;
            avg_len = bm25_pkg::AVG_RST;
            k_q12   = bm25_pkg::K_RST;
            b_q12   = bm25_pkg::B_RST;
            score_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                unique case (bm25_pkg::t_cfg_idx'(i_cfg_idx))
                    bm25_pkg::CFG_TOTAL_DOCS: n_docs  = i_cfg_data;
                    bm25_pkg::CFG_AVG_LEN:    avg_len = i_cfg_data;
                    bm25_pkg::CFG_K:          k_q12   = i_cfg_data[15:0];
                    bm25_pkg::CFG_B:          b_q12   = i_cfg_data[12:0];
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                score_q.insert(score_q.size(), bm25(i_s_axis_tdata[31:0],
                               i_s_axis_tdata[63:32], i_s_axis_tdata[95:64]));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = {i_m_axis_tdata[31:0], i_m_axis_tdata[33:32]};
                if (score_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected transfer score %0d status %0d", $time,
                             $signed(got.score), got.status);
                end else begin
                    want = score_q.pop_front();
                    if (got.score !== want.score) begin
                        o_errors++;
                        $display("%0t: score expected %0d actual %0d", $time,
                                 $signed(want.score), $signed(got.score));
                    end
                    if (got.status !== want.status) begin
                        o_errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, got.status);
                    end
                end
            end
        end
        o_pending = score_q.size();
    end

endmodule

>>> sim/bm25_term_score_tb.sv
`timescale 1ns / 100ps

module bm25_term_score_tb;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic        cfg_we = 0;
    logic [1:0]  cfg_idx = bm25_pkg::CFG_TOTAL_DOCS;
    logic [31:0] cfg_data = '0;
    int          errors;
    int          pending;
    bit          idling = 1;
    bit [31:0]   n_docs = 0;

    always #5 i_clk = ~i_clk;

    bm25_term_score DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .o_m_axis_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    bm25_term_score_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .i_m_axis_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    task automatic send_posting(bit [31:0] df, bit [31:0] tf_cnt, bit [31:0] dl);
        int gap;
        gap = idling ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {dl, tf_cnt, df};
        forever begin
            @(negedge i_clk);
            if (s_tready) break;
        end
        @(posedge i_clk);
    endtask

    task automatic write_reg(bm25_pkg::t_cfg_idx idx, bit [31:0] val);
        cfg_we   <= 1;
        cfg_idx  <= idx;
        cfg_data <= val;
        if (idx == bm25_pkg::CFG_TOTAL_DOCS) n_docs = val;
        @(posedge i_clk);
        cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (110) @(posedge i_clk);
    endtask

    function automatic bit [31:0] rand_count();
        int w;
        w = $urandom_range(1, 32);
        return $urandom & (32'hFFFF_FFFF >> (32 - w));
    endfunction

    task automatic random_postings(int count);
        bit [31:0] df;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) idling = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       df = 0;
                1:       df = (n_docs == 32'hFFFF_FFFF) ? n_docs : n_docs + 1 + ($urandom & 32'hFF);
                2:       df = rand_count();
                3:       df = n_docs;
                default: df = (n_docs == 0) ? 1 : (rand_count() % n_docs) + 1;
            endcase
            send_posting(df, ($urandom_range(0, 20) == 0) ? 0 : rand_count(),
                         ($urandom_range(0, 20) == 0) ? 0 : rand_count());
        end
    endtask

    initial begin
        @(posedge i_clk);
        forever begin
            int gap;
            gap = idling ? $urandom_range(0, 18) : 0;
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1;
            forever begin
                @(negedge i_clk);
                if (m_tvalid) break;
            end
            @(posedge i_clk);
        end
    end

    initial begin
        #5_000_000;
        $display("bm25_term_score_tb: FAIL");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // defaults: N is zero so every nonzero posting is too frequent
        send_posting(1, 1, 1);
        send_posting(0, 5, 5);
        drain();
        write_reg(bm25_pkg::CFG_TOTAL_DOCS, 1000);
        send_posting(0, 1, 1);
        send_posting(1, 0, 1);
        send_posting(1, 1, 0);
        send_posting(1000, 3, 100);
        send_posting(1001, 3, 100);
        send_posting(1, 1, 1);
        send_posting(500, 2, 256);
        send_posting(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_posting(32'hFFFF_FFFF, 1, 1);
        drain();
        write_reg(bm25_pkg::CFG_TOTAL_DOCS, 32'hFFFF_FFFF);
        write_reg(bm25_pkg::CFG_AVG_LEN, 0);
        write_reg(bm25_pkg::CFG_K, 16'hFFFF);
        write_reg(bm25_pkg::CFG_B, 13'h1FFF);
        send_posting(1, 32'hFFFF_FFFF, 1);
        send_posting(1, 1, 32'hFFFF_FFFF);
        send_posting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_posting(32'h8000_0000, 7, 32'h8000_0000);
        send_posting(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();
        random_postings(150);
        drain();

        write_reg(bm25_pkg::CFG_K, 0);
        write_reg(bm25_pkg::CFG_B, 0);
        write_reg(bm25_pkg::CFG_AVG_LEN, 32'hFFFF_FFFF);
        random_postings(150);
        drain();
        write_reg(bm25_pkg::CFG_TOTAL_DOCS, 1);
        write_reg(bm25_pkg::CFG_B, bm25_pkg::B_ONE);
        write_reg(bm25_pkg::CFG_K, bm25_pkg::K_RST);
        write_reg(bm25_pkg::CFG_AVG_LEN, 1);
        random_postings(100);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(bm25_pkg::CFG_TOTAL_DOCS, rand_count());
            write_reg(bm25_pkg::CFG_AVG_LEN, rand_count());
            write_reg(bm25_pkg::CFG_K, $urandom_range(0, 16'hFFFF));
            write_reg(bm25_pkg::CFG_B, $urandom_range(0, 13'h1FFF));
            random_postings(140);
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("bm25_term_score_tb: PASS");
        else
            $display("bm25_term_score_tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/bm25_pkg.sv
rtl/bm25_log2.sv
rtl/bm25_div.sv
rtl/bm25_term_score.sv
sim/bm25_term_score_checker.sv
sim/bm25_term_score_tb.sv
